[hdl/multilevel_feedback_queue_macros.svh]
// assertion macros for the multilevel feedback queue scheduler
// no dependencies; included by the modules that carry checks
`ifndef MULTILEVEL_FEEDBACK_QUEUE_MACROS_SVH
`define MULTILEVEL_FEEDBACK_QUEUE_MACROS_SVH
`ifndef NO_ASSERTIONS
`define MFQ_ASSERT_IMPLY(lbl, clk, rstn, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |-> (cons)) \
        else $error(msg);
`define MFQ_ASSERT_NEXT(lbl, clk, rstn, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |=> (cons)) \
        else $error(msg);
`else
`define MFQ_ASSERT_IMPLY(lbl, clk, rstn, ante, cons, msg)
`define MFQ_ASSERT_NEXT(lbl, clk, rstn, ante, cons, msg)
`endif
`endif

[hdl/mfq_pkg.sv]
// shared types and codes of the multilevel feedback queue scheduler
// no dependencies
`timescale 1ns / 1ps
package mfq_pkg;

    localparam int PID_W  = 4;
    localparam int POS_W  = 6;   // wide enough for the largest slot count

    typedef enum logic [2:0] {
        KIND_ENQ   = 3'd0,
        KIND_DEQ   = 3'd1,
        KIND_HEAD  = 3'd2,
        KIND_QUANT = 3'd3,
        KIND_READY = 3'd4,
        KIND_TICK  = 3'd5,
        KIND_SETP  = 3'd6
    } kind_t;

    typedef enum logic [1:0] {
        STS_OK       = 2'd0,
        STS_FULL     = 2'd1,
        STS_BAD      = 2'd2,
        STS_NO_READY = 2'd3
    } status_t;

    typedef enum logic [1:0] {
        REG_BASE_QUANTUM   = 2'd0,
        REG_WAIT_LIMIT     = 2'd1,
        REG_AGING_INTERVAL = 2'd2
    } reg_idx_t;

    typedef enum logic [1:0] {
        S_IDLE  = 2'd0,
        S_LEVEL = 2'd1,
        S_SCAN  = 2'd2
    } state_t;

    typedef struct packed {
        logic             push;
        logic             remove;
        logic [PID_W-1:0] pid;
        logic [POS_W-1:0] pos;
    } row_ctl_t;

    typedef struct packed {
        logic shift;
        logic load;
    } cell_ctl_t;

endpackage

[hdl/mfq_cell.sv]
// one queue slot: holds a process id, takes its right neighbor on a shift
// depends on mfq_pkg
`timescale 1ns / 1ps
module mfq_cell (
    input  logic                       aclk,
    input  mfq_pkg::cell_ctl_t         ctl,
    input  logic [mfq_pkg::PID_W-1:0]  nbr_pid,
    input  logic [mfq_pkg::PID_W-1:0]  load_pid,
    output logic [mfq_pkg::PID_W-1:0]  pid
);
    logic [mfq_pkg::PID_W-1:0] pid_reg, pid_next;

    always_comb begin
        pid_next = pid_reg;
        if (ctl.shift) begin
            pid_next = nbr_pid;
        end else if (ctl.load) begin
            pid_next = load_pid;
        end
    end

    always_ff @(posedge aclk) begin
        pid_reg <= pid_next;
    end

    assign pid = pid_reg;
endmodule

[hdl/mfq_row.sv]
// one priority level: a row of slot cells plus its fill count
// depends on mfq_pkg, mfq_cell and the macro header
`timescale 1ns / 1ps
`include "multilevel_feedback_queue_macros.svh"
module mfq_row #(
    parameter int SLOTS = 16
) (
    input  logic                               aclk,
    input  logic                               aresetn,
    input  mfq_pkg::row_ctl_t                  ctl,
    input  logic [$clog2(SLOTS)-1:0]           rd_idx,
    output logic [mfq_pkg::PID_W-1:0]          rd_pid,
    output logic [mfq_pkg::PID_W-1:0]          head_pid,
    output logic [$clog2(SLOTS+1)-1:0]         count
);
    localparam int SL_W  = $clog2(SLOTS);
    localparam int CNT_W = $clog2(SLOTS+1);

    logic [CNT_W-1:0] count_reg, count_next;
    logic [mfq_pkg::PID_W-1:0] pid_q [SLOTS];
    mfq_pkg::cell_ctl_t        cctl  [SLOTS];
    logic [SL_W-1:0]           pos;

    assign pos = SL_W'(ctl.pos);

    genvar k;
    generate
        for (k = 0; k < SLOTS; k++) begin : g_cell
            logic [mfq_pkg::PID_W-1:0] nbr;
            if (k + 1 < SLOTS) begin : g_mid
                assign nbr = pid_q[k+1];
            end else begin : g_end
                assign nbr = pid_q[k];
            end
            assign cctl[k].shift = ctl.remove && (SL_W'(k) >= pos);
            assign cctl[k].load  = ctl.push && (CNT_W'(k) == count_reg);
            mfq_cell u_cell (
                .aclk     (aclk),
                .ctl      (cctl[k]),
                .nbr_pid  (nbr),
                .load_pid (ctl.pid),
                .pid      (pid_q[k])
            );
        end
    endgenerate

    always_comb begin
        count_next = count_reg;
        if (ctl.push) begin
            count_next = count_reg + 1'b1;
        end else if (ctl.remove) begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            count_reg <= '0;
        end else begin
            count_reg <= count_next;
        end
    end

    assign rd_pid   = pid_q[rd_idx];
    assign head_pid = pid_q[0];
    assign count    = count_reg;

    `MFQ_ASSERT_IMPLY(a_count_bound, aclk, aresetn, 1'b1, 32'(count_reg) <= SLOTS, "row overfull")
    `MFQ_ASSERT_IMPLY(a_one_op, aclk, aresetn, ctl.push, !ctl.remove, "push and remove together")
    `MFQ_ASSERT_NEXT(a_remove_dec, aclk, aresetn, ctl.remove, count_reg == $past(count_reg) - 1'b1, "remove count")
endmodule

[hdl/multilevel_feedback_queue.sv]
// channel | dir | tdata / tuser
// s_      | in  | tuser kind; tdata level, position, process_id, ready_flag, now
// m_      | out | tdata status, out_process, out_position, out_level, out_quantum, moved
// apb     | in  | base_quantum @0, wait_limit @4, aging_interval @8
// every kind except the aging tick answers in the cycle after acceptance
// an aging tick checks each level from 1 upward in S_LEVEL and scans a due level
//   in S_SCAN: the scan walks one slot of one row per cycle
// one transaction is in flight at a time; input is held off while a result waits
// reset is synchronous; all queues come up empty with no clearing pass
// depends on mfq_pkg, mfq_row, mfq_cell and the macro header
`timescale 1ns / 1ps
`include "multilevel_feedback_queue_macros.svh"
module multilevel_feedback_queue #(
    parameter int LEVELS    = 4,
    parameter int SLOTS     = 16,
    parameter int PROCESSES = 16
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [79:0] s_tdata,  // level, position, process_id, ready_flag, now, pad
    input  logic [2:0]  s_tuser,  // kind
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [47:0] m_tdata,  // status, out_process, out_position, out_level,
                                  // out_quantum, moved_count, pad
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [3:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);
    localparam int LV_W  = $clog2(LEVELS);
    localparam int SL_W  = $clog2(SLOTS);
    localparam int CNT_W = $clog2(SLOTS+1);
    localparam int PIX_W = $clog2(PROCESSES);
    localparam logic [LV_W-1:0] LAST_LV = LV_W'(LEVELS - 1);

    // configuration
    logic [23:0] base_q_reg, base_q_next;
    logic [31:0] max_wait_reg, max_wait_next;
    logic [15:0] interval_reg, interval_next;

    // scheduler state
    mfq_pkg::state_t     state_reg, state_next;
    logic [31:0]         counter_reg, counter_next;
    logic [31:0]         last_aged_reg [LEVELS];
    logic [31:0]         last_aged_next [LEVELS];
    logic                ready_reg [PROCESSES];
    logic                ready_next [PROCESSES];
    logic [63:0]         since_reg [PROCESSES];
    logic [63:0]         since_next [PROCESSES];
    logic [LV_W-1:0]     lvl_reg, lvl_next;
    logic [CNT_W-1:0]    k_reg, k_next;
    logic [5:0]          moved_reg, moved_next;
    logic [63:0]         now_reg, now_next;

    // result register
    logic        out_valid_reg, out_valid_next;
    logic [1:0]  sts_reg, sts_next;
    logic [3:0]  oproc_reg, oproc_next;
    logic [3:0]  opos_reg, opos_next;
    logic [1:0]  olev_reg, olev_next;
    logic [26:0] oq_reg, oq_next;
    logic [5:0]  omov_reg, omov_next;

    // rows
    mfq_pkg::row_ctl_t          row_ctl [LEVELS];
    logic [mfq_pkg::PID_W-1:0]  rd_pid  [LEVELS];
    logic [mfq_pkg::PID_W-1:0]  head    [LEVELS];
    logic [CNT_W-1:0]           cnt     [LEVELS];
    logic [SL_W-1:0]            rd_idx;

    // input fields
    logic [2:0]  in_kind;
    logic [1:0]  in_level;
    logic [3:0]  in_pos;
    logic [3:0]  in_pid;
    logic        in_rdy;
    logic [63:0] in_now;
    logic        accept;

    assign in_kind  = s_tuser;
    assign in_level = s_tdata[1:0];
    assign in_pos   = s_tdata[5:2];
    assign in_pid   = s_tdata[9:6];
    assign in_rdy   = s_tdata[10];
    assign in_now   = s_tdata[74:11];

    assign s_tready = (state_reg == mfq_pkg::S_IDLE) && !out_valid_reg;
    assign accept   = s_tvalid && s_tready;

    // idle reads the dequeue slot, the aging scan reads its walking slot
    assign rd_idx = (state_reg == mfq_pkg::S_IDLE) ? SL_W'(in_pos) : SL_W'(k_reg);

    genvar g;
    generate
        for (g = 0; g < LEVELS; g++) begin : g_row
            mfq_row #(.SLOTS(SLOTS)) u_row (
                .aclk     (aclk),
                .aresetn  (aresetn),
                .ctl      (row_ctl[g]),
                .rd_idx   (rd_idx),
                .rd_pid   (rd_pid[g]),
                .head_pid (head[g]),
                .count    (cnt[g])
            );
        end
    endgenerate

    // config port
    logic cfg_wr;
    assign cfg_wr = psel && penable && pwrite && pready;
    assign pready = 1'b1;

    always_comb begin
        base_q_next   = base_q_reg;
        max_wait_next = max_wait_reg;
        interval_next = interval_reg;
        if (cfg_wr) begin
            unique case (paddr[3:2])
                mfq_pkg::REG_BASE_QUANTUM:   base_q_next   = pwdata[23:0];
                mfq_pkg::REG_WAIT_LIMIT:     max_wait_next = pwdata;
                mfq_pkg::REG_AGING_INTERVAL: interval_next = pwdata[15:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        unique case (paddr[3:2])
            mfq_pkg::REG_BASE_QUANTUM:   prdata = {8'd0, base_q_reg};
            mfq_pkg::REG_WAIT_LIMIT:     prdata = max_wait_reg;
            mfq_pkg::REG_AGING_INTERVAL: prdata = {16'd0, interval_reg};
            default:                     prdata = 32'd0;
        endcase
    end

    // aging step terms
    logic [LV_W-1:0]           lvl_up;
    logic [mfq_pkg::PID_W-1:0] scan_pid;
    logic [63:0]               scan_since;
    logic [63:0]               scan_wait;
    logic                      scan_promote;
    logic                      lvl_due;
    logic                      scan_more;

    assign lvl_up     = lvl_reg - 1'b1;
    assign scan_pid   = rd_pid[lvl_reg];
    assign scan_since = since_reg[PIX_W'(scan_pid)];
    assign scan_wait  = (now_reg >= scan_since) ? (now_reg - scan_since) : 64'd0;
    assign scan_promote = (32'(scan_pid) < PROCESSES) && (scan_wait > {32'd0, max_wait_reg});
    assign lvl_due    = (counter_reg - last_aged_reg[lvl_reg]) > {16'd0, interval_reg};
    assign scan_more  = k_reg < cnt[lvl_reg];

    // next state
    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            mfq_pkg::S_IDLE: begin
                if (accept && in_kind == mfq_pkg::KIND_TICK) begin
                    state_next = mfq_pkg::S_LEVEL;
                end
            end
            mfq_pkg::S_LEVEL: begin
                if (lvl_due) begin
                    state_next = mfq_pkg::S_SCAN;
                end else if (lvl_reg == LAST_LV) begin
                    state_next = mfq_pkg::S_IDLE;
                end
            end
            mfq_pkg::S_SCAN: begin
                if (!scan_more) begin
                    state_next = (lvl_reg == LAST_LV) ? mfq_pkg::S_IDLE : mfq_pkg::S_LEVEL;
                end
            end
            default: state_next = mfq_pkg::S_IDLE;
        endcase
    end

    // datapath and outputs
    logic             lv_ok;
    logic [LV_W-1:0]  li;
    logic             rq_found;
    logic [1:0]       rq_lev;

    assign lv_ok = 32'(in_level) < LEVELS;
    assign li    = LV_W'(in_level);

    always_comb begin
        rq_found = 1'b0;
        rq_lev   = 2'd0;
        for (int l = LEVELS - 1; l >= 0; l--) begin
            if (cnt[l] != '0 && 32'(head[l]) < PROCESSES && ready_reg[PIX_W'(head[l])]) begin
                rq_found = 1'b1;
                rq_lev   = 2'(l);
            end
        end
    end

    always_comb begin
        counter_next   = counter_reg;
        last_aged_next = last_aged_reg;
        ready_next     = ready_reg;
        since_next     = since_reg;
        lvl_next       = lvl_reg;
        k_next         = k_reg;
        moved_next     = moved_reg;
        now_next       = now_reg;
        out_valid_next = out_valid_reg && !m_tready;
        sts_next   = sts_reg;
        oproc_next = oproc_reg;
        opos_next  = opos_reg;
        olev_next  = olev_reg;
        oq_next    = oq_reg;
        omov_next  = omov_reg;
        for (int l = 0; l < LEVELS; l++) begin
            row_ctl[l] = '0;
        end

        unique case (state_reg)
            mfq_pkg::S_IDLE: begin
                if (accept) begin
                    out_valid_next = 1'b1;
                    sts_next   = mfq_pkg::STS_OK;
                    oproc_next = '0;
                    opos_next  = '0;
                    olev_next  = '0;
                    oq_next    = '0;
                    omov_next  = '0;
                    case (in_kind)
                        mfq_pkg::KIND_ENQ: begin
                            if (!lv_ok) begin
                                sts_next = mfq_pkg::STS_BAD;
                            end else if (32'(cnt[li]) >= SLOTS) begin
                                sts_next = mfq_pkg::STS_FULL;
                            end else begin
                                row_ctl[li].push = 1'b1;
                                row_ctl[li].pid  = in_pid;
                                opos_next = 4'(cnt[li]);
                            end
                        end
                        mfq_pkg::KIND_DEQ: begin
                            if (!lv_ok || 32'(in_pos) >= 32'(cnt[li])) begin
                                sts_next = mfq_pkg::STS_BAD;
                            end else begin
                                row_ctl[li].remove = 1'b1;
                                row_ctl[li].pos    = mfq_pkg::POS_W'(in_pos);
                                oproc_next = rd_pid[li];
                            end
                        end
                        mfq_pkg::KIND_HEAD: begin
                            if (!lv_ok || cnt[li] == '0) begin
                                sts_next = mfq_pkg::STS_BAD;
                            end else begin
                                oproc_next = head[li];
                            end
                        end
                        mfq_pkg::KIND_QUANT: begin
                            if (!lv_ok) begin
                                sts_next = mfq_pkg::STS_BAD;
                            end else begin
                                oq_next = {3'd0, base_q_reg} << in_level;
                            end
                        end
                        mfq_pkg::KIND_READY: begin
                            if (rq_found) begin
                                olev_next = rq_lev;
                            end else begin
                                sts_next = mfq_pkg::STS_NO_READY;
                            end
                        end
                        mfq_pkg::KIND_TICK: begin
                            out_valid_next = 1'b0;
                            counter_next   = counter_reg + 32'd1;
                            lvl_next       = LV_W'(1);
                            moved_next     = '0;
                            now_next       = in_now;
                        end
                        mfq_pkg::KIND_SETP: begin
                            if (32'(in_pid) >= PROCESSES) begin
                                sts_next = mfq_pkg::STS_BAD;
                            end else begin
                                ready_next[PIX_W'(in_pid)] = in_rdy;
                                since_next[PIX_W'(in_pid)] = in_now;
                            end
                        end
                        default: sts_next = mfq_pkg::STS_BAD;
                    endcase
                end
            end
            mfq_pkg::S_LEVEL: begin
                k_next = '0;
                if (!lvl_due) begin
                    if (lvl_reg == LAST_LV) begin
                        out_valid_next = 1'b1;
                        sts_next   = mfq_pkg::STS_OK;
                        oproc_next = '0;
                        opos_next  = '0;
                        olev_next  = '0;
                        oq_next    = '0;
                        omov_next  = moved_reg;
                    end else begin
                        lvl_next = lvl_reg + 1'b1;
                    end
                end
            end
            mfq_pkg::S_SCAN: begin
                if (scan_more) begin
                    if (scan_promote && 32'(cnt[lvl_up]) < SLOTS) begin
                        row_ctl[lvl_reg].remove = 1'b1;
                        row_ctl[lvl_reg].pos    = mfq_pkg::POS_W'(k_reg);
                        row_ctl[lvl_up].push    = 1'b1;
                        row_ctl[lvl_up].pid     = scan_pid;
                        moved_next = moved_reg + 6'd1;
                    end else begin
                        k_next = k_reg + 1'b1;
                    end
                end else begin
                    last_aged_next[lvl_reg] = counter_reg;
                    if (lvl_reg == LAST_LV) begin
                        out_valid_next = 1'b1;
                        sts_next   = mfq_pkg::STS_OK;
                        oproc_next = '0;
                        opos_next  = '0;
                        olev_next  = '0;
                        oq_next    = '0;
                        omov_next  = moved_reg;
                    end else begin
                        lvl_next = lvl_reg + 1'b1;
                    end
                end
            end
            default: ;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            base_q_reg    <= 24'd10000;
            max_wait_reg  <= 32'd1000000;
            interval_reg  <= 16'd10;
            state_reg     <= mfq_pkg::S_IDLE;
            counter_reg   <= '0;
            out_valid_reg <= 1'b0;
            lvl_reg       <= '0;
            k_reg         <= '0;
            moved_reg     <= '0;
            for (int l = 0; l < LEVELS; l++) begin
                last_aged_reg[l] <= '0;
            end
            for (int p = 0; p < PROCESSES; p++) begin
                ready_reg[p] <= 1'b0;
                since_reg[p] <= '0;
            end
        end else begin
            base_q_reg     <= base_q_next;
            max_wait_reg   <= max_wait_next;
            interval_reg   <= interval_next;
            state_reg      <= state_next;
            counter_reg    <= counter_next;
            out_valid_reg  <= out_valid_next;
            lvl_reg        <= lvl_next;
            k_reg          <= k_next;
            moved_reg      <= moved_next;
            last_aged_reg  <= last_aged_next;
            ready_reg      <= ready_next;
            since_reg      <= since_next;
        end
    end

    always_ff @(posedge aclk) begin
        now_reg   <= now_next;
        sts_reg   <= sts_next;
        oproc_reg <= oproc_next;
        opos_reg  <= opos_next;
        olev_reg  <= olev_next;
        oq_reg    <= oq_next;
        omov_reg  <= omov_next;
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {3'd0, omov_reg, oq_reg, olev_reg, opos_reg, oproc_reg, sts_reg};

    `MFQ_ASSERT_IMPLY(a_busy_empty, aclk, aresetn, state_reg != mfq_pkg::S_IDLE, !out_valid_reg, "result pending during scan")
    `MFQ_ASSERT_NEXT(a_tick_start, aclk, aresetn, accept && in_kind == mfq_pkg::KIND_TICK, state_reg == mfq_pkg::S_LEVEL && lvl_reg == LV_W'(1), "tick did not start aging")
    `MFQ_ASSERT_NEXT(a_quick_reply, aclk, aresetn, accept && in_kind != mfq_pkg::KIND_TICK, out_valid_reg, "missing reply")
endmodule

[bench/mfq_checker.sv]
// scoreboard for the multilevel feedback queue scheduler: tracks the queues,
// registers and process table, predicts each result and compares it field by field
// depends on mfq_pkg
`timescale 1ns / 1ps
module mfq_checker (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    input  logic        s_tready,
    input  logic [79:0] s_tdata,
    input  logic [2:0]  s_tuser,
    input  logic        m_tvalid,
    input  logic        m_tready,
    input  logic [47:0] m_tdata,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic        pready,
    input  logic [3:0]  paddr,
    input  logic [31:0] pwdata,
    output int          fail_count,
    output int          pending
);
    localparam int NLEV  = 4;
    localparam int NSLOT = 16;
    localparam int NPROC = 16;

    // highest field first, so status lands in the lowest bits
    typedef struct packed {
        logic [5:0]       moved;
        logic [26:0]      quantum;
        logic [1:0]       lev;
        logic [3:0]       slot;
        logic [3:0]       proc_id;
        mfq_pkg::status_t status;
    } sched_result_t;

    logic [23:0] base_quantum;
    logic [31:0] wait_limit;
    logic [15:0] aging_interval;

    logic [3:0]  slots [NLEV][NSLOT];
    int          counts [NLEV];
    logic [31:0] last_aged [NLEV];
    logic [31:0] tick_count;
    logic        ready_flag [NPROC];
    logic [63:0] ready_since [NPROC];

    sched_result_t expected_results[$];

    function automatic logic [3:0] take_out(int lv, int pos);
        logic [3:0] pid;
        pid = slots[lv][pos];
        for (int k = pos; k + 1 < counts[lv]; k++) slots[lv][k] = slots[lv][k + 1];
        counts[lv]--;
        return pid;
    endfunction

    function automatic int promote_waiting(int lv, logic [63:0] now);
        int moved;
        int k;
        logic [3:0] pid;
        logic [63:0] wait_ns;
        moved = 0;
        k = 0;
        while (k < counts[lv]) begin
            pid = slots[lv][k];
            wait_ns = (now >= ready_since[pid]) ? now - ready_since[pid] : 64'd0;
            if (wait_ns > {32'd0, wait_limit} && counts[lv - 1] < NSLOT) begin
                pid = take_out(lv, k);
                slots[lv - 1][counts[lv - 1]] = pid;
                counts[lv - 1]++;
                moved++;
            end else begin
                k++;
            end
        end
        return moved;
    endfunction

    function automatic sched_result_t predict_schedule(logic [2:0] kind, logic [79:0] d);
        sched_result_t r;
        int lv;
        int pos;
        logic [3:0] pid;
        logic [63:0] now;
        int moved;
        lv  = int'(d[1:0]);
        pos = int'(d[5:2]);
        pid = d[9:6];
        now = d[74:11];
        r = '0;
        r.status = mfq_pkg::STS_OK;
        case (kind)
            mfq_pkg::KIND_ENQ: begin
                if (counts[lv] >= NSLOT) begin
                    r.status = mfq_pkg::STS_FULL;
                end else begin
                    slots[lv][counts[lv]] = pid;
                    r.slot = 4'(counts[lv]);
                    counts[lv]++;
                end
            end
            mfq_pkg::KIND_DEQ: begin
                if (pos >= counts[lv]) r.status = mfq_pkg::STS_BAD;
                else r.proc_id = take_out(lv, pos);
            end
            mfq_pkg::KIND_HEAD: begin
                if (counts[lv] == 0) r.status = mfq_pkg::STS_BAD;
                else r.proc_id = slots[lv][0];
            end
            mfq_pkg::KIND_QUANT: r.quantum = 27'({3'd0, base_quantum} << lv);
            mfq_pkg::KIND_READY: begin
                r.status = mfq_pkg::STS_NO_READY;
                for (int l = NLEV - 1; l >= 0; l--) begin
                    if (counts[l] != 0 && ready_flag[slots[l][0]]) begin
                        r.status = mfq_pkg::STS_OK;
                        r.lev = 2'(l);
                    end
                end
            end
            mfq_pkg::KIND_TICK: begin
                moved = 0;
                tick_count++;
                for (int l = 1; l < NLEV; l++) begin
                    if (tick_count - last_aged[l] > {16'd0, aging_interval}) begin
                        moved += promote_waiting(l, now);
                        last_aged[l] = tick_count;
                    end
                end
                r.moved = 6'(moved);
            end
            mfq_pkg::KIND_SETP: begin
                ready_flag[pid]  = d[10];
                ready_since[pid] = now;
            end
            default: r.status = mfq_pkg::STS_BAD;
        endcase
        return r;
    endfunction

    task automatic report_mismatch(string field, logic [31:0] got, logic [31:0] want);
        $display("%0t mismatch on %s: got %0d, expected %0d", $time, field, got, want);
        fail_count++;
    endtask

    initial fail_count = 0;

    always @(posedge aclk) begin
        sched_result_t got;
        sched_result_t want;
        if (!aresetn) begin
            base_quantum   = 24'd10000;
            wait_limit     = 32'd1000000;
            aging_interval = 16'd10;
            for (int l = 0; l < NLEV; l++) begin
                counts[l] = 0;
                last_aged[l] = '0;
            end
            for (int p = 0; p < NPROC; p++) begin
                ready_flag[p] = 1'b0;
                ready_since[p] = '0;
            end
            tick_count = '0;
            expected_results.delete();
        end else begin
            if (psel && penable && pwrite && pready) begin
                case (mfq_pkg::reg_idx_t'(paddr[3:2]))
                    mfq_pkg::REG_BASE_QUANTUM:   base_quantum   = pwdata[23:0];
                    mfq_pkg::REG_WAIT_LIMIT:     wait_limit     = pwdata;
                    mfq_pkg::REG_AGING_INTERVAL: aging_interval = pwdata[15:0];
                    default: ;
                endcase
            end
            if (m_tvalid && m_tready) begin
                got = m_tdata[44:0];
                if (expected_results.size() == 0) begin
                    $display("%0t result transaction with nothing expected", $time);
                    fail_count++;
                end else begin
                    want = expected_results.pop_front();
                    if (got.status !== want.status)
                        report_mismatch("status", 32'(got.status), 32'(want.status));
                    if (got.proc_id !== want.proc_id)
                        report_mismatch("out_process", 32'(got.proc_id), 32'(want.proc_id));
                    if (got.slot !== want.slot)
                        report_mismatch("out_position", 32'(got.slot), 32'(want.slot));
                    if (got.lev !== want.lev)
                        report_mismatch("out_level", 32'(got.lev), 32'(want.lev));
                    if (got.quantum !== want.quantum)
                        report_mismatch("out_quantum", 32'(got.quantum), 32'(want.quantum));
                    if (got.moved !== want.moved)
                        report_mismatch("moved_count", 32'(got.moved), 32'(want.moved));
                end
            end
            if (s_tvalid && s_tready)
                expected_results.push_back(predict_schedule(s_tuser, s_tdata));
        end
        pending = expected_results.size();
    end

endmodule

[bench/tb_top.sv]
// top of the scheduler testbench: clock, reset, register setup and request stimulus
// depends on mfq_pkg, multilevel_feedback_queue and mfq_checker
`timescale 1ns / 1ps
module tb_top;

    localparam logic [2:0] KIND_UNUSED = 3'd7;
    localparam int SETTLE_CYCLES = 100;

    logic        aclk = 1'b0;
    logic        aresetn = 1'b0;
    logic        s_tvalid = 1'b0;
    logic        s_tready;
    logic [79:0] s_tdata = '0;   // level, position, process_id, ready_flag, now, pad
    logic [2:0]  s_tuser = '0;   // kind
    logic        m_tvalid;
    logic        m_tready = 1'b0;
    logic [47:0] m_tdata;        // status, out_process, out_position, out_level,
                                 // out_quantum, moved_count, pad
    logic        psel = 1'b0;
    logic        penable = 1'b0;
    logic        pwrite = 1'b0;
    logic [3:0]  paddr = '0;
    logic [31:0] pwdata = '0;
    logic [31:0] prdata;
    logic        pready;

    int          fail_count;
    int          pending;
    int          send_idle_pct = 0;
    int          recv_idle_pct = 0;
    logic [63:0] sim_now = '0;
    int          now_step = 1000;

    always begin
        #4 aclk = 1'b1;
        #4 aclk = 1'b0;
    end

    multilevel_feedback_queue dut (.*);

    mfq_checker u_checker (.*);

    always @(posedge aclk)
        m_tready <= ($urandom_range(99) >= recv_idle_pct);

    task automatic send_request(logic [2:0] kind, logic [1:0] lv, logic [3:0] pos,
                                logic [3:0] pid, logic rdy, logic [63:0] now);
        // sender idles cycle by cycle
        while ($urandom_range(99) < send_idle_pct) begin
            s_tvalid <= 1'b0;
            @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tuser  <= kind;
        s_tdata  <= {5'd0, now, rdy, pid, pos, lv};
        forever begin
            @(negedge aclk);
            if (s_tready) break;
        end
        @(posedge aclk);
    endtask

    task automatic write_reg(mfq_pkg::reg_idx_t idx, logic [31:0] value);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {idx, 2'b00};
        pwdata  <= value;
        @(posedge aclk);
        penable <= 1'b1;
        @(posedge aclk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
    endtask

    task automatic drain;
        s_tvalid <= 1'b0;
        @(posedge aclk);
        while (pending != 0) @(posedge aclk);
        repeat (SETTLE_CYCLES) @(posedge aclk);
    endtask

    task automatic random_request;
        int pick;
        logic [63:0] now;
        pick = $urandom_range(99);
        sim_now = sim_now + 64'($urandom_range(0, now_step));
        now = ($urandom_range(49) == 0) ? {$urandom, $urandom} : sim_now;
        if (pick < 30)
            send_request(mfq_pkg::KIND_ENQ, 2'($urandom), 4'd0, 4'($urandom), 1'b0, now);
        else if (pick < 45)
            send_request(mfq_pkg::KIND_DEQ, 2'($urandom),
                         ($urandom_range(3) == 0) ? 4'($urandom_range(15))
                         : 4'($urandom_range(3)), 4'd0, 1'b0, now);
        else if (pick < 52)
            send_request(mfq_pkg::KIND_HEAD, 2'($urandom), 4'd0, 4'd0, 1'b0, now);
        else if (pick < 57)
            send_request(mfq_pkg::KIND_QUANT, 2'($urandom), 4'd0, 4'd0, 1'b0, now);
        else if (pick < 65)
            send_request(mfq_pkg::KIND_READY, 2'd0, 4'd0, 4'd0, 1'b0, now);
        else if (pick < 80)
            send_request(mfq_pkg::KIND_TICK, 2'd0, 4'd0, 4'd0, 1'b0, now);
        else if (pick < 98)
            send_request(mfq_pkg::KIND_SETP, 2'd0, 4'd0, 4'($urandom), 1'($urandom), now);
        else
            send_request(KIND_UNUSED, 2'($urandom), 4'($urandom), 4'($urandom),
                         1'($urandom), now);
    endtask

    initial begin
        repeat (6) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // directed: empty queues, every kind, field extremes
        send_request(mfq_pkg::KIND_HEAD, 2'd3, 4'd0, 4'd0, 1'b0, 64'd0);
        send_request(mfq_pkg::KIND_DEQ, 2'd0, 4'd0, 4'd0, 1'b0, 64'd0);
        send_request(mfq_pkg::KIND_READY, 2'd0, 4'd0, 4'd0, 1'b0, 64'd0);
        for (int l = 0; l < 4; l++)
            send_request(mfq_pkg::KIND_QUANT, 2'(l), 4'd0, 4'd0, 1'b0, 64'd0);
        send_request(mfq_pkg::KIND_ENQ, 2'd3, 4'd0, 4'd15, 1'b0, 64'd0);
        send_request(mfq_pkg::KIND_ENQ, 2'd3, 4'd0, 4'd0, 1'b0, 64'd0);
        send_request(mfq_pkg::KIND_ENQ, 2'd1, 4'd0, 4'd5, 1'b0, 64'd0);
        send_request(mfq_pkg::KIND_READY, 2'd0, 4'd0, 4'd0, 1'b0, 64'd0);
        send_request(mfq_pkg::KIND_SETP, 2'd0, 4'd0, 4'd0, 1'b1, 64'd0);
        send_request(mfq_pkg::KIND_SETP, 2'd0, 4'd0, 4'd15, 1'b1, '1);
        send_request(mfq_pkg::KIND_READY, 2'd0, 4'd0, 4'd0, 1'b0, 64'd0);
        send_request(mfq_pkg::KIND_HEAD, 2'd3, 4'd0, 4'd0, 1'b0, 64'd0);
        send_request(mfq_pkg::KIND_DEQ, 2'd3, 4'd15, 4'd0, 1'b0, 64'd0);
        send_request(mfq_pkg::KIND_TICK, 2'd0, 4'd0, 4'd0, 1'b0, 64'd5000000);
        send_request(mfq_pkg::KIND_TICK, 2'd0, 4'd0, 4'd0, 1'b0, '1);
        send_request(KIND_UNUSED, 2'd3, 4'd15, 4'd15, 1'b1, '1);
        send_request(mfq_pkg::KIND_DEQ, 2'd3, 4'd0, 4'd0, 1'b0, 64'd0);
        drain();

        for (int ph = 0; ph < 4; ph++) begin
            send_idle_pct = 0;
            recv_idle_pct = 0;
            case (ph)
                0: begin
                    write_reg(mfq_pkg::REG_BASE_QUANTUM, 32'd10000);
                    write_reg(mfq_pkg::REG_WAIT_LIMIT, 32'd1000000);
                    write_reg(mfq_pkg::REG_AGING_INTERVAL, 32'd10);
                    now_step = 200000;
                end
                1: begin
                    write_reg(mfq_pkg::REG_BASE_QUANTUM, 32'd1);
                    write_reg(mfq_pkg::REG_WAIT_LIMIT, 32'd0);
                    write_reg(mfq_pkg::REG_AGING_INTERVAL, 32'd0);
                    now_step = 20;
                end
                2: begin
                    write_reg(mfq_pkg::REG_BASE_QUANTUM, 32'hFFFFFF);
                    write_reg(mfq_pkg::REG_WAIT_LIMIT, 32'hFFFFFFFF);
                    write_reg(mfq_pkg::REG_AGING_INTERVAL, 32'hFFFF);
                    now_step = 32'h7FFFFFFF;
                end
                default: begin
                    write_reg(mfq_pkg::REG_BASE_QUANTUM, 32'h5A5A5A);
                    write_reg(mfq_pkg::REG_WAIT_LIMIT, 32'd3000);
                    write_reg(mfq_pkg::REG_AGING_INTERVAL, 32'd2);
                    now_step = 1000;
                end
            endcase
            case (ph)
                0: begin send_idle_pct = 33; recv_idle_pct = 57; end
                1: begin send_idle_pct = 57; recv_idle_pct = 33; end
                default: ;
            endcase
            for (int i = 0; i < 412; i++) begin
                // after 200 requests, hold the input until every result is back
                if (i == 200) drain();
                random_request();
            end
            drain();
        end

        if (fail_count == 0)
            $display("Test completed successfully");
        else
            $display("Test completed with failures");
        $finish;
    end

    initial begin
        #20ms;
        $display("Test completed with failures");
        $finish;
    end

endmodule
